### rtl/core/sitda_pkg.sv
// Shared constants and state types for the signed integer to decimal ASCII converter.
// No dependencies.
package sitda_pkg;

    localparam logic [7:0] ASCII_ZERO  = 8'd48;
    localparam logic [7:0] ASCII_NINE  = 8'd57;
    localparam logic [7:0] ASCII_MINUS = 8'd45;
    localparam logic [7:0] ASCII_D     = 8'd100;

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_CONV = 3'b010,
        F_PUSH = 3'b100
    } front_state_t;

    typedef enum logic [4:0] {
        B_IDLE  = 5'b00001,
        B_MINUS = 5'b00010,
        B_ZERO  = 5'b00100,
        B_DLET  = 5'b01000,
        B_DIGIT = 5'b10000
    } back_state_t;

endpackage

### rtl/core/sitda_front.sv
// Front end: takes a signed value, forms its magnitude and converts it to BCD
// one bit per cycle (shift and add-3). Depends on sitda_pkg.
module sitda_front #(
    parameter int VALUE_BITS = 32,
    parameter int NDIG       = 10,
    parameter int IDX_W      = 4
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [VALUE_BITS-1:0]  s_value,
    output logic                          q_valid,
    input  logic                          q_ready,
    output logic [NDIG*4+IDX_W:0]         q_data
);

    localparam int CNT_W = $clog2(VALUE_BITS);

    sitda_pkg::front_state_t state_reg, state_next;
    logic                    neg_reg, neg_next;
    logic [VALUE_BITS-1:0]   shift_reg, shift_next;
    logic [NDIG*4-1:0]       bcd_reg, bcd_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [NDIG*4-1:0]       bcd_adj;
    logic [IDX_W-1:0]        top_idx;
    logic [VALUE_BITS-1:0]   raw;
    logic [VALUE_BITS-1:0]   mag;

    assign raw = s_value;
    assign mag = raw[VALUE_BITS-1] ? (~raw + VALUE_BITS'(1)) : raw;

    always_comb begin
        logic [3:0] dig;
        dig = 4'd0;
        for (int i = 0; i < NDIG; i++) begin
            dig = bcd_reg[4*i +: 4];
            bcd_adj[4*i +: 4] = (dig >= 4'd5) ? dig + 4'd3 : dig;
        end
    end

    always_comb begin
        top_idx = '0;
        for (int i = 0; i < NDIG; i++) begin
            if (bcd_reg[4*i +: 4] != 4'd0) begin
                top_idx = IDX_W'(i);
            end
        end
    end

    assign s_ready = (state_reg == sitda_pkg::F_IDLE);
    assign q_valid = (state_reg == sitda_pkg::F_PUSH);
    assign q_data  = {neg_reg, top_idx, bcd_reg};

    always_comb begin
        state_next = state_reg;
        neg_next   = neg_reg;
        shift_next = shift_reg;
        bcd_next   = bcd_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            sitda_pkg::F_IDLE: begin
                if (s_valid) begin
                    neg_next   = raw[VALUE_BITS-1];
                    shift_next = mag;
                    bcd_next   = '0;
                    cnt_next   = '0;
                    state_next = sitda_pkg::F_CONV;
                end
            end
            sitda_pkg::F_CONV: begin
                bcd_next   = {bcd_adj[NDIG*4-2:0], shift_reg[VALUE_BITS-1]};
                shift_next = {shift_reg[VALUE_BITS-2:0], 1'b0};
                cnt_next   = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(VALUE_BITS - 1)) begin
                    state_next = sitda_pkg::F_PUSH;
                end
            end
            sitda_pkg::F_PUSH: begin
                if (q_ready) begin
                    state_next = sitda_pkg::F_IDLE;
                end
            end
            default: state_next = sitda_pkg::F_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sitda_pkg::F_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        neg_reg   <= neg_next;
        shift_reg <= shift_next;
        bcd_reg   <= bcd_next;
        cnt_reg   <= cnt_next;
    end

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == sitda_pkg::F_CONV) |-> (cnt_reg <= CNT_W'(VALUE_BITS - 1)))
        else $error("front bit count out of range");

endmodule

### rtl/core/sitda_fifo.sv
// Two-entry queue between front and back end.
// No dependencies.
module sitda_fifo #(
    parameter int WIDTH = 45
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    logic [WIDTH-1:0] mem [2];
    logic             wr_ptr_reg, rd_ptr_reg;
    logic [1:0]       count_reg;
    logic             push, pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = mem[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= 2'd2)
        else $error("queue count overflow");

endmodule

### rtl/core/sitda_back.sv
// Back end: pops a converted value and emits its text, one character per cycle
// while m_ready allows, through an output register. Depends on sitda_pkg.
module sitda_back #(
    parameter int NDIG  = 10,
    parameter int IDX_W = 4
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  q_valid,
    output logic                  q_ready,
    input  logic [NDIG*4+IDX_W:0] q_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [7:0]            m_char_code,
    output logic                  m_last_char
);

    sitda_pkg::back_state_t state_reg, state_next;
    logic [NDIG*4-1:0]      bcd_reg;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic                   m_valid_reg, m_valid_next;
    logic [7:0]             m_code_reg, m_code_next;
    logic                   m_last_reg, m_last_next;
    logic                   q_neg;
    logic [IDX_W-1:0]       q_top;
    logic [NDIG*4-1:0]      q_bcd;
    logic                   adv, load, take;
    logic [3:0]             dig;

    assign {q_neg, q_top, q_bcd} = q_data;
    assign adv = !m_valid_reg || m_ready;
    assign dig = bcd_reg[idx_reg*4 +: 4];

    assign m_valid     = m_valid_reg;
    assign m_char_code = m_code_reg;
    assign m_last_char = m_last_reg;

    always_comb begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        m_code_next = m_code_reg;
        m_last_next = m_last_reg;
        load        = 1'b0;
        take        = 1'b0;
        q_ready     = 1'b0;
        unique case (state_reg)
            sitda_pkg::B_IDLE: begin
                q_ready = 1'b1;
                if (q_valid) begin
                    take       = 1'b1;
                    state_next = q_neg ? sitda_pkg::B_MINUS : sitda_pkg::B_ZERO;
                end
            end
            sitda_pkg::B_MINUS: begin
                if (adv) begin
                    load        = 1'b1;
                    m_code_next = sitda_pkg::ASCII_MINUS;
                    m_last_next = 1'b0;
                    state_next  = sitda_pkg::B_ZERO;
                end
            end
            sitda_pkg::B_ZERO: begin
                if (adv) begin
                    load        = 1'b1;
                    m_code_next = sitda_pkg::ASCII_ZERO;
                    m_last_next = 1'b0;
                    state_next  = sitda_pkg::B_DLET;
                end
            end
            sitda_pkg::B_DLET: begin
                if (adv) begin
                    load        = 1'b1;
                    m_code_next = sitda_pkg::ASCII_D;
                    m_last_next = 1'b0;
                    state_next  = sitda_pkg::B_DIGIT;
                end
            end
            sitda_pkg::B_DIGIT: begin
                if (adv) begin
                    load        = 1'b1;
                    m_code_next = sitda_pkg::ASCII_ZERO + {4'd0, dig};
                    m_last_next = (idx_reg == '0);
                    if (idx_reg == '0) begin
                        state_next = sitda_pkg::B_IDLE;
                    end else begin
                        idx_next = idx_reg - IDX_W'(1);
                    end
                end
            end
            default: state_next = sitda_pkg::B_IDLE;
        endcase
        m_valid_next = load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= sitda_pkg::B_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_code_reg <= m_code_next;
        m_last_reg <= m_last_next;
        if (take) begin
            bcd_reg <= q_bcd;
            idx_reg <= q_top;
        end else begin
            idx_reg <= idx_next;
        end
    end

    a_code_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_code_reg == sitda_pkg::ASCII_MINUS ||
                         m_code_reg == sitda_pkg::ASCII_D ||
                         (m_code_reg >= sitda_pkg::ASCII_ZERO &&
                          m_code_reg <= sitda_pkg::ASCII_NINE)))
        else $error("illegal character code");

    a_last_is_digit: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_last_reg) |-> (m_code_reg >= sitda_pkg::ASCII_ZERO &&
                                         m_code_reg <= sitda_pkg::ASCII_NINE))
        else $error("final character is not a digit");

    a_last_ends_text: assert property (@(posedge aclk) disable iff (!aresetn)
        (load && m_last_next) |=> (state_reg == sitda_pkg::B_IDLE))
        else $error("text did not end after final character");

endmodule

### rtl/core/signed_int_to_decimal_ascii.sv
// Signed integer to decimal ASCII text converter, top level.
// Depends on sitda_pkg, sitda_front, sitda_fifo, sitda_back.
//
// Each accepted value (low VALUE_BITS bits, two's complement) comes out as
// ASCII text, one character per item: an optional '-', then "0d", then the
// decimal digits without leading zeros; m_last_char marks the final one.
// The front end converts the magnitude to BCD one bit per cycle and takes a
// new value only once the previous one has gone into the queue; a two-entry
// queue feeds the back end, which fetches each value in its idle state and
// then sends one character per cycle while m_ready allows, through its
// output register.
module signed_int_to_decimal_ascii #(
    parameter int VALUE_BITS = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [VALUE_BITS-1:0] s_value,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [7:0]                   m_char_code,
    output logic                         m_last_char
);

    localparam int NDIG  = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int IDX_W = $clog2(NDIG);
    localparam int QW    = NDIG * 4 + IDX_W + 1;

    logic          fq_valid, fq_ready;
    logic [QW-1:0] fq_data;
    logic          bq_valid, bq_ready;
    logic [QW-1:0] bq_data;

    sitda_front #(
        .VALUE_BITS (VALUE_BITS),
        .NDIG       (NDIG),
        .IDX_W      (IDX_W)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_value (s_value),
        .q_valid (fq_valid),
        .q_ready (fq_ready),
        .q_data  (fq_data)
    );

    sitda_fifo #(
        .WIDTH (QW)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_data   (fq_data),
        .out_valid (bq_valid),
        .out_ready (bq_ready),
        .out_data  (bq_data)
    );

    sitda_back #(
        .NDIG  (NDIG),
        .IDX_W (IDX_W)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (bq_valid),
        .q_ready     (bq_ready),
        .q_data      (bq_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_char_code (m_char_code),
        .m_last_char (m_last_char)
    );

endmodule
